// ===== rtl/assert_macros.svh =====
// Assertion shorthands for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/plti_pkg.sv =====
package plti_pkg;

    localparam int DATA_W = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic CFG_POINT_COUNT = 1'b0;
    localparam logic CFG_NO_VALUE    = 1'b1;

    typedef logic signed [DATA_W-1:0] sample_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RDL,
        ST_RANGE,
        ST_SCAN,
        ST_MUL,
        ST_DSTART,
        ST_DIV,
        ST_DONE
    } plti_state_t;

endpackage

// ===== rtl/plti_mem.sv =====
module plti_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/plti_div.sv =====
module plti_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [2*plti_pkg::DATA_W-1:0] dividend,
    input  logic [plti_pkg::DATA_W-1:0]   divisor,
    output logic                         done,
    output logic [plti_pkg::DATA_W-1:0]   quotient
);

    // The upper half of the dividend must be below the divisor, so the
    // quotient fits in one word and one bit is produced per cycle.
    localparam int W = plti_pkg::DATA_W;

    logic           busy_reg;
    logic           done_reg;
    logic [$clog2(W)-1:0] cnt_reg;
    logic [W-1:0]   rem_reg;
    logic [W-1:0]   dq_reg;
    logic [W-1:0]   den_reg;
    logic [W:0]     rem_sh;
    logic [W:0]     rem_sub;
    logic           ge;

    assign rem_sh  = {rem_reg, dq_reg[W-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign ge      = (rem_sh >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == {$clog2(W){1'b1}})
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend[2*W-1:W];
            dq_reg  <= dividend[W-1:0];
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
            dq_reg  <= {dq_reg[W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== rtl/piecewise_linear_table_interp.sv =====
// A load keeps the block idle: the next item is accepted in the following cycle.
// A query scans the table one entry per cycle through the read ports of both
// memories, then runs one multiply and a bit-serial divide; the scan is longer
// the later the matching segment lies. Out-of-span queries skip the scan and divide.
// Reset clears the control and configuration registers, not the data path or the tables.
module piecewise_linear_table_interp #(
    parameter int MAX_POINTS  = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic                   opcode,
    input  logic [5:0]             point_index,
    input  logic signed [31:0]     point_time,
    input  logic signed [31:0]     point_value,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [31:0]     result_value,
    output logic                   in_range,
    input  logic                   cfg_we,
    input  logic                   cfg_index,
    input  logic [31:0]            cfg_data
);

    localparam int W        = plti_pkg::DATA_W;
    localparam int ADDR_W   = $clog2(MAX_POINTS);
    localparam int IDX_W    = ((ADDR_W > 6) ? ADDR_W : 6) + 1;
    localparam int CNT_W    = ($clog2(MAX_POINTS + 1) > 7) ? $clog2(MAX_POINTS + 1) : 7;
    localparam int SAT_BITS = (SAMPLE_BITS < 32) ? SAMPLE_BITS : 32;
    localparam logic signed [W+1:0] SAT_HI = (34'sd1 <<< (SAT_BITS - 1)) - 34'sd1;
    localparam logic signed [W+1:0] SAT_LO = -SAT_HI - 34'sd1;

    plti_pkg::plti_state_t state_reg, state_next;

    logic [6:0]          point_count_reg;
    plti_pkg::sample_t   no_value_reg;

    plti_pkg::sample_t   t_reg;
    plti_pkg::sample_t   prev_t_reg;
    plti_pkg::sample_t   prev_v_reg;
    logic [ADDR_W-1:0]   last_addr_reg;
    logic [ADDR_W-1:0]   idx_reg;
    logic [W-1:0]        mag_reg;
    logic [W-1:0]        num_reg;
    logic [W-1:0]        den_reg;
    logic                neg_reg;
    logic [2*W-1:0]      prod_reg;
    plti_pkg::sample_t   res_reg;
    logic                hit_reg;

    logic                out_valid_reg;
    plti_pkg::sample_t   result_reg;
    logic                in_range_reg;

    logic                in_xfer;
    logic                query_xfer;
    logic                mem_we;
    logic [IDX_W-1:0]    idx_ext;
    logic [ADDR_W-1:0]   rd_addr;
    logic [W-1:0]        time_rdata;
    logic [W-1:0]        value_rdata;
    plti_pkg::sample_t   t_rd;
    plti_pkg::sample_t   v_rd;
    logic [CNT_W-1:0]    cnt_ext;
    logic [CNT_W-1:0]    n_eff;
    logic [CNT_W-1:0]    n_m1;
    logic                n_ge2;
    logic                in_span;
    logic                at_first;
    logic                seg_hit;
    logic signed [W:0]   dv;
    logic signed [W:0]   dv_abs;
    logic signed [W:0]   num_w;
    logic signed [W:0]   den_w;
    logic [2*W-1:0]      prod_next;
    logic                div_start;
    logic                div_done;
    logic [W-1:0]        div_q;
    logic signed [W+1:0] v0_ext;
    logic signed [W+1:0] q_ext;
    logic signed [W+1:0] sum;
    plti_pkg::sample_t   sat;
    logic                out_free;

    assign in_ready   = (state_reg == plti_pkg::ST_IDLE);
    assign in_xfer    = in_valid && in_ready;
    assign query_xfer = in_xfer && (opcode == plti_pkg::OP_QUERY);

    assign idx_ext = IDX_W'(point_index);
    assign mem_we  = in_xfer && (opcode == plti_pkg::OP_LOAD)
                     && (idx_ext < IDX_W'(MAX_POINTS));

    plti_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (W)
    ) u_time_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_ext[ADDR_W-1:0]),
        .wdata (point_time),
        .raddr (rd_addr),
        .rdata (time_rdata)
    );

    plti_mem #(
        .DEPTH (MAX_POINTS),
        .WIDTH (W)
    ) u_value_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (idx_ext[ADDR_W-1:0]),
        .wdata (point_value),
        .raddr (rd_addr),
        .rdata (value_rdata)
    );

    assign t_rd = $signed(time_rdata);
    assign v_rd = $signed(value_rdata);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg <= '0;
            no_value_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                plti_pkg::CFG_POINT_COUNT: point_count_reg <= cfg_data[6:0];
                plti_pkg::CFG_NO_VALUE:    no_value_reg    <= $signed(cfg_data);
            endcase
        end
    end

    assign cnt_ext = CNT_W'(point_count_reg);
    assign n_eff   = (cnt_ext > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : cnt_ext;
    assign n_m1    = n_eff - CNT_W'(1);
    assign n_ge2   = (n_eff >= CNT_W'(2));

    // In the range check, prev_t_reg holds the first time and t_rd the last.
    assign in_span  = (t_reg >= prev_t_reg) && (t_reg <= t_rd);
    assign at_first = (t_reg == prev_t_reg);
    assign seg_hit  = (t_reg > prev_t_reg) && (t_reg <= t_rd);

    assign dv     = (W+1)'(v_rd) - (W+1)'(prev_v_reg);
    assign dv_abs = dv[W] ? -dv : dv;
    assign num_w  = (W+1)'(t_reg) - (W+1)'(prev_t_reg);
    assign den_w  = (W+1)'(t_rd) - (W+1)'(prev_t_reg);

    assign prod_next = {{W{1'b0}}, mag_reg} * {{W{1'b0}}, num_reg};

    plti_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign v0_ext = (W+2)'(prev_v_reg);
    assign q_ext  = $signed({2'b00, div_q});
    assign sum    = neg_reg ? (v0_ext - q_ext) : (v0_ext + q_ext);
    assign sat    = (sum > SAT_HI) ? SAT_HI[W-1:0]
                  : (sum < SAT_LO) ? SAT_LO[W-1:0]
                  : sum[W-1:0];

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= plti_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rd_addr    = '0;
        div_start  = 1'b0;
        unique case (state_reg)
            plti_pkg::ST_IDLE:
            begin
                if (query_xfer)
                begin
                    state_next = n_ge2 ? plti_pkg::ST_RD0 : plti_pkg::ST_DONE;
                end
            end
            plti_pkg::ST_RD0:
            begin
                rd_addr    = '0;
                state_next = plti_pkg::ST_RDL;
            end
            plti_pkg::ST_RDL:
            begin
                rd_addr    = last_addr_reg;
                state_next = plti_pkg::ST_RANGE;
            end
            plti_pkg::ST_RANGE:
            begin
                rd_addr = ADDR_W'(1);
                if (!in_span || at_first)
                begin
                    state_next = plti_pkg::ST_DONE;
                end
                else
                begin
                    state_next = plti_pkg::ST_SCAN;
                end
            end
            plti_pkg::ST_SCAN:
            begin
                rd_addr = idx_reg + ADDR_W'(1);
                if (seg_hit)
                begin
                    state_next = plti_pkg::ST_MUL;
                end
                else if (idx_reg == last_addr_reg)
                begin
                    state_next = plti_pkg::ST_DONE;
                end
            end
            plti_pkg::ST_MUL:
            begin
                state_next = plti_pkg::ST_DSTART;
            end
            plti_pkg::ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = plti_pkg::ST_DIV;
            end
            plti_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = plti_pkg::ST_DONE;
                end
            end
            plti_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = plti_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = plti_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            plti_pkg::ST_IDLE:
            begin
                if (query_xfer)
                begin
                    t_reg         <= point_time;
                    last_addr_reg <= n_m1[ADDR_W-1:0];
                    res_reg       <= no_value_reg;
                    hit_reg       <= 1'b0;
                end
            end
            plti_pkg::ST_RDL:
            begin
                prev_t_reg <= t_rd;
                prev_v_reg <= v_rd;
            end
            plti_pkg::ST_RANGE:
            begin
                idx_reg <= ADDR_W'(1);
                if (in_span && at_first)
                begin
                    res_reg <= prev_v_reg;
                    hit_reg <= 1'b1;
                end
            end
            plti_pkg::ST_SCAN:
            begin
                if (seg_hit)
                begin
                    mag_reg <= dv_abs[W-1:0];
                    neg_reg <= dv[W];
                    num_reg <= num_w[W-1:0];
                    den_reg <= den_w[W-1:0];
                end
                else
                begin
                    prev_t_reg <= t_rd;
                    prev_v_reg <= v_rd;
                    idx_reg    <= idx_reg + ADDR_W'(1);
                end
            end
            plti_pkg::ST_MUL:
            begin
                prod_reg <= prod_next;
            end
            plti_pkg::ST_DIV:
            begin
                if (div_done)
                begin
                    res_reg <= sat;
                    hit_reg <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == plti_pkg::ST_DONE && out_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == plti_pkg::ST_DONE && out_free)
        begin
            result_reg   <= res_reg;
            in_range_reg <= hit_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_reg;
    assign in_range     = in_range_reg;

endmodule

// ===== rtl/plti_checker.sv =====
`include "assert_macros.svh"

module plti_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               opcode,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] result_value,
    input logic               in_range
);

    logic        query_xfer;
    logic        load_xfer;
    logic        out_stall;
    logic [32:0] out_word;

    assign query_xfer = in_valid && in_ready && (opcode == plti_pkg::OP_QUERY);
    assign load_xfer  = in_valid && in_ready && (opcode == plti_pkg::OP_LOAD);
    assign out_stall  = out_valid && !out_ready;
    assign out_word   = {result_value, in_range};

    `ASSERT_NEXT(a_query_busy, clk, rst_n, query_xfer, !in_ready, "Query left the input open.")
    `ASSERT_NEXT(a_load_no_result, clk, rst_n, load_xfer && !out_valid, !out_valid, "Load gave a result.")
    `ASSERT_SAME(a_result_after_work, clk, rst_n, $rose(out_valid), $past(!in_ready), "Result with no query.")
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, out_valid && $stable(out_word), "Stalled result changed.")

endmodule

bind piecewise_linear_table_interp plti_checker u_plti_checker (.*);

// ===== tb/tb_piecewise_linear_table_interp.sv =====
`timescale 1ns / 1ps

module tb_piecewise_linear_table_interp;
    import plti_pkg::*;

    localparam int    RANDOM_ITEMS   = 1450;
    localparam int    SETTLE_CYCLES  = 8;
    localparam int    END_CYCLES     = 120;
    localparam int    HOLD_CYCLES    = 400;
    localparam int    WATCHDOG_LIMIT = 5000;
    localparam int    TABLE_DEPTH    = 64;
    localparam longint SAT_HI        = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LO        = -64'sh0000_0000_8000_0000;

    typedef struct packed {
        sample_t value;
        logic    in_range;
    } result_t;

    typedef enum logic [1:0] {
        ROW_CFG,
        ROW_LOAD,
        ROW_QUERY
    } row_kind_t;

    typedef struct packed {
        row_kind_t  kind;
        logic       reg_sel;
        logic [5:0] slot;
        logic [31:0] time_or_data;
        sample_t    value;
        logic       typed;
        sample_t    exp_value;
        logic       exp_in_range;
    } row_t;

    localparam int DIRECTED_ROWS = 26;

    localparam row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h0000_0000, 32'h0, 1'b1, 32'h0000_0000, 1'b0},
        '{ROW_CFG,   CFG_NO_VALUE,    6'd0, 32'h8000_0000, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG,   CFG_POINT_COUNT, 6'd0, 32'd1,         32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_LOAD,  CFG_POINT_COUNT, 6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_LOAD,  CFG_POINT_COUNT, 6'd1, 32'h0000_0000, 32'h8000_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h8000_0000, 32'h0, 1'b1, 32'h8000_0000, 1'b0},
        '{ROW_LOAD,  CFG_POINT_COUNT, 6'd2, 32'h0001_0000, 32'h0002_0000, 1'b0, 32'h0, 1'b0},
        '{ROW_LOAD,  CFG_POINT_COUNT, 6'd3, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG,   CFG_POINT_COUNT, 6'd0, 32'd4,         32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h8000_0000, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h0000_0000, 32'h0, 1'b1, 32'h8000_0000, 1'b1},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b1},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'hC000_0000, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h0000_8000, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h0001_0001, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG,   CFG_NO_VALUE,    6'd0, 32'h7FFF_FFFF, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG,   CFG_POINT_COUNT, 6'd0, 32'd3,         32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h7FFF_FFFF, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h0001_0000, 32'h0, 1'b1, 32'h0002_0000, 1'b1},
        '{ROW_LOAD,  CFG_POINT_COUNT, 6'd1, 32'h7000_0000, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h0000_8000, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h6000_0000, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG,   CFG_POINT_COUNT, 6'd0, 32'd2,         32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'hFFFF_0000, 32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_CFG,   CFG_POINT_COUNT, 6'd0, 32'd0,         32'h0, 1'b0, 32'h0, 1'b0},
        '{ROW_QUERY, CFG_POINT_COUNT, 6'd0, 32'h0000_0000, 32'h0, 1'b1, 32'h7FFF_FFFF, 1'b0}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        opcode = OP_LOAD;
    logic [5:0]  point_index = '0;
    sample_t     point_time = '0;
    sample_t     point_value = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    sample_t     result_value;
    logic        in_range;
    logic        cfg_we = 1'b0;
    logic        cfg_index = CFG_POINT_COUNT;
    logic [31:0] cfg_data = '0;

    sample_t     bp_time [TABLE_DEPTH];
    sample_t     bp_value [TABLE_DEPTH];
    logic [6:0]  active_points = '0;
    sample_t     fallback_value = '0;

    result_t     expected_results [$];
    int          mismatch_count = 0;
    int          items_sent = 0;
    int          stall_cycles = 0;
    int          holds_asked = 0;
    int          holds_granted = 0;
    bit          burst = 1'b0;

    piecewise_linear_table_interp dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic result_t interpolate_query(sample_t t);
        result_t     r;
        int          n;
        longint      v0, dv, res;
        logic [63:0] mag, num, den, step;
        r.value = fallback_value;
        r.in_range = 1'b0;
        n = (active_points > 7'd64) ? TABLE_DEPTH : int'(active_points);
        if (n >= 2 && t >= bp_time[0] && t <= bp_time[n-1])
        begin
            if (t == bp_time[0])
            begin
                r.value = bp_value[0];
                r.in_range = 1'b1;
            end
            else
            begin
                for (int i = 0; i + 1 < n; i++)
                begin
                    if (!r.in_range && t > bp_time[i] && t <= bp_time[i+1])
                    begin
                        v0 = longint'(bp_value[i]);
                        dv = longint'(bp_value[i+1]) - v0;
                        mag = (dv < 0) ? -dv : dv;
                        num = longint'(t) - longint'(bp_time[i]);
                        den = longint'(bp_time[i+1]) - longint'(bp_time[i]);
                        step = (mag * num) / den;
                        res = (dv < 0) ? v0 - longint'(step) : v0 + longint'(step);
                        if (res > SAT_HI)
                            res = SAT_HI;
                        if (res < SAT_LO)
                            res = SAT_LO;
                        r.value = sample_t'(res);
                        r.in_range = 1'b1;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic sample_t pick_query_time();
        int          n, seg, sel;
        longint      lo, hi, span, t;
        logic [63:0] off;
        n = (active_points > 7'd64) ? TABLE_DEPTH : int'(active_points);
        sel = $urandom_range(0, 99);
        if (n < 2 || sel < 15)
            return sample_t'($urandom);
        lo = longint'(bp_time[0]);
        hi = longint'(bp_time[n-1]);
        if (sel < 25)
        begin
            if ($urandom_range(0, 1) == 0)
                t = lo - 1 - longint'($urandom_range(0, 1000));
            else
                t = hi + 1 + longint'($urandom_range(0, 1000));
            if (t < SAT_LO)
                t = SAT_LO;
            if (t > SAT_HI)
                t = SAT_HI;
            return sample_t'(t);
        end
        if (sel < 40)
            return bp_time[$urandom_range(0, n - 1)];
        seg = $urandom_range(0, n - 2);
        lo = longint'(bp_time[seg]);
        span = longint'(bp_time[seg+1]) - lo;
        if (span <= 0)
            return bp_time[seg+1];
        off = ({32'd0, $urandom} * 64'(span)) >> 32;
        return sample_t'(lo + 1 + longint'(off));
    endfunction

    task automatic send_item(logic op, logic [5:0] slot, sample_t t, sample_t v,
                             bit typed, result_t typed_res);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 19);
        if (gap != 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        opcode <= op;
        point_index <= slot;
        point_time <= t;
        point_value <= v;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (op == OP_QUERY)
            expected_results.push_back(typed ? typed_res : interpolate_query(t));
        else
        begin
            bp_time[slot] = t;
            bp_value[slot] = v;
        end
        items_sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(logic sel, logic [31:0] data);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (sel == CFG_POINT_COUNT)
            active_points = data[6:0];
        else
            fallback_value = data;
    endtask

    task automatic load_table(int n);
        int      times [$];
        longint  t_walk, v_walk;
        bit      full_range, value_walk;
        sample_t v;
        full_range = $urandom_range(0, 1);
        value_walk = $urandom_range(0, 1);
        t_walk = longint'(int'($urandom)) >>> 1;
        v_walk = longint'(int'($urandom)) >>> 1;
        for (int i = 0; i < n; i++)
        begin
            if (full_range)
                times.push_back(int'($urandom));
            else
            begin
                times.push_back(int'(t_walk));
                if ($urandom_range(0, 15) != 0)
                    t_walk += longint'($urandom_range(1, 1 << 20));
            end
        end
        if (full_range)
            times.sort();
        for (int i = 0; i < n; i++)
        begin
            v = value_walk ? sample_t'(v_walk) : sample_t'($urandom);
            v_walk += longint'($urandom_range(0, 1 << 21)) - (1 << 20);
            send_item(OP_LOAD, 6'(i), sample_t'(times[i]), v, 1'b0, '0);
        end
    endtask

    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            if (holds_granted < holds_asked)
            begin
                stall = HOLD_CYCLES;
                holds_granted++;
            end
            else
                stall = burst ? 0 : $urandom_range(0, 19);
            if (stall != 0)
            begin
                @(negedge clk);
                out_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            @(negedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transfer: value %h in_range %b",
                             result_value, in_range);
            end
            else
            begin
                want = expected_results.pop_front();
                if (result_value !== want.value || in_range !== want.in_range)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h/%b, got %h/%b",
                                 want.value, want.in_range, result_value, in_range);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        row_t        row;
        result_t     typed_res;
        int          count, n_eff, quota, start_items, phase;
        logic [31:0] nv;
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            row = DIRECTED[r];
            typed_res.value = row.exp_value;
            typed_res.in_range = row.exp_in_range;
            case (row.kind)
                ROW_CFG:
                begin
                    settle();
                    write_register(row.reg_sel, row.time_or_data);
                end
                ROW_LOAD:
                    send_item(OP_LOAD, row.slot, row.time_or_data, row.value, 1'b0, '0);
                default:
                    send_item(OP_QUERY, row.slot, row.time_or_data, row.value,
                              row.typed, typed_res);
            endcase
        end

        start_items = items_sent;
        phase = 0;
        while (items_sent - start_items < RANDOM_ITEMS)
        begin
            settle();
            case (phase)
                0: count = 2;
                1: count = 64;
                2: count = 127;
                3: count = 0;
                4: count = 1;
                5: count = 65;
                default: count = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 64)
                                                            : $urandom_range(2, 8);
            endcase
            case (phase)
                0: nv = 32'h8000_0000;
                1: nv = 32'h7FFF_FFFF;
                2: nv = 32'h0000_0000;
                default: nv = $urandom;
            endcase
            if ($urandom_range(0, 1) == 0)
            begin
                write_register(CFG_POINT_COUNT, {25'($urandom), 7'(count)});
                write_register(CFG_NO_VALUE, nv);
            end
            else
            begin
                write_register(CFG_NO_VALUE, nv);
                write_register(CFG_POINT_COUNT, {25'($urandom), 7'(count)});
            end
            burst = (phase == 2) || ($urandom_range(0, 4) == 0);
            if (phase == 6 || phase == 11)
                holds_asked++;
            n_eff = (count > TABLE_DEPTH) ? TABLE_DEPTH : count;
            if (n_eff >= 2)
                load_table(n_eff);
            quota = $urandom_range(60, 110);
            repeat (quota)
            begin
                if ($urandom_range(0, 99) < 5)
                    send_item(OP_LOAD, 6'($urandom), $urandom, $urandom, 1'b0, '0);
                else
                    send_item(OP_QUERY, 6'($urandom), pick_query_time(), $urandom,
                              1'b0, '0);
            end
            phase++;
        end

        settle();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
